@@ hw/rtl/stpq_pkg.sv @@
// ----------------------------------------------------------------------------
// stpq_pkg
// Shared types and codes for the stable priority task queue.
// ----------------------------------------------------------------------------
package stpq_pkg;

	localparam int PRIO_W = 8;
	localparam int HND_W  = 8;
	localparam int DATA_W = 8;
	localparam int FILL_W = 5;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_POPPED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [HND_W-1:0]  hnd;
		logic [DATA_W-1:0] dat;
	} entry_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic   insert_en;
		logic   pop_en;
		entry_t item;
	} cell_ctl_t;

endpackage

@@ hw/rtl/stable_priority_task_queue_top.sv @@
// ----------------------------------------------------------------------------
// stable_priority_task_queue_top
// Bounded priority task queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each input transfer is an insert or a pop and yields exactly one result
// transfer through the output register. Every cell compares its own entry
// with the incoming priority and shifts right or left in the same cycle, so
// the queue takes one item per clock as long as the output side does not
// stall; the depth of the row (QUEUE_DEPTH) sets area, not latency. Lower
// priority values leave first, equal priorities in arrival order. An insert
// into a full queue and a pop from an empty queue leave the queue unchanged
// and report status full or empty with zero payload.
module stable_priority_task_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [stpq_pkg::PRIO_W-1:0]  priority_req,
	input  logic [stpq_pkg::HND_W-1:0]   handler,
	input  logic [stpq_pkg::DATA_W-1:0]  data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [stpq_pkg::PRIO_W-1:0]  out_priority,
	output logic [stpq_pkg::HND_W-1:0]   out_handler,
	output logic [stpq_pkg::DATA_W-1:0]  out_data,
	output logic [stpq_pkg::FILL_W-1:0]  fill_count
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	stpq_pkg::status_t   status_q;
	stpq_pkg::entry_t    head_q;
	logic [CNT_W-1:0]    count_next;

	logic                accept;
	logic                is_pop;
	logic                full;
	logic                empty;
	stpq_pkg::cell_ctl_t ctl;
	stpq_pkg::status_t   status_next;

	stpq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
	logic                cell_keep  [QUEUE_DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_pop   = (stpq_pkg::cmd_t'(cmd) == stpq_pkg::CMD_POP);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		ctl.item.prio = priority_req;
		ctl.item.hnd  = handler;
		ctl.item.dat  = data;
		ctl.insert_en = accept && !is_pop && !full;
		ctl.pop_en    = accept && is_pop && !empty;
		count_next    = count_q;
		if (is_pop) begin
			if (empty) begin
				status_next = stpq_pkg::ST_EMPTY;
			end else begin
				status_next = stpq_pkg::ST_POPPED;
				count_next  = count_q - CNT_W'(1);
			end
		end else begin
			if (full) begin
				status_next = stpq_pkg::ST_FULL;
			end else begin
				status_next = stpq_pkg::ST_INSERTED;
				count_next  = count_q + CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic             occ;
		logic             lkeep;
		stpq_pkg::entry_t lent;
		stpq_pkg::entry_t rent;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign lkeep = 1'b1;
			assign lent  = ctl.item;
		end else begin : g_mid
			assign lkeep = cell_keep[i-1];
			assign lent  = cell_entry[i-1];
		end

		// last slot reloads itself on pop; it falls beyond the fill count
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign rent = cell_entry[i];
		end else begin : g_inner
			assign rent = cell_entry[i+1];
		end

		stpq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (occ),
			.left_keep   (lkeep),
			.left_entry  (lent),
			.right_entry (rent),
			.keep        (cell_keep[i]),
			.entry_q     (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload: head entry on a successful pop, zero otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_next;
			if (ctl.pop_en) begin
				head_q <= cell_entry[0];
			end else begin
				head_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_priority = head_q.prio;
	assign out_handler  = head_q.hnd;
	assign out_data     = head_q.dat;
	assign fill_count   = stpq_pkg::FILL_W'(count_q);

endmodule

@@ hw/rtl/stpq_cell.sv @@
// ----------------------------------------------------------------------------
// stpq_cell
// One slot of the sorted row: holds an entry, shifts right on insert and
// left on pop.
// ----------------------------------------------------------------------------
module stpq_cell (
	input  logic               clk,
	input  stpq_pkg::cell_ctl_t ctl,
	input  logic               occupied,
	input  logic               left_keep,
	input  stpq_pkg::entry_t   left_entry,
	input  stpq_pkg::entry_t   right_entry,
	output logic               keep,
	output stpq_pkg::entry_t   entry_q
);

	// an occupied slot with lower or equal priority stays ahead of the new item
	assign keep = occupied && (entry_q.prio <= ctl.item.prio);

	always_ff @(posedge clk) begin
		if (ctl.insert_en && !keep) begin
			if (left_keep) begin
				entry_q <= ctl.item;
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctl.pop_en) begin
			entry_q <= right_entry;
		end
	end

endmodule
